@@ hw/rtl/tcs_pkg.sv @@
package tcs_pkg;

  // APB address width: three registers at byte offsets 0, 4, 8
  localparam int unsigned ADDR_W = 4;

  // TCP flag bits and flag combinations
  localparam logic [7:0] FLAG_FIN    = 8'h01;
  localparam logic [7:0] FLAG_SYN    = 8'h02;
  localparam logic [7:0] FLAG_RST    = 8'h04;
  localparam logic [7:0] FLAG_ACK    = 8'h10;
  localparam logic [7:0] FLAG_PSHACK = 8'h18;
  localparam logic [7:0] FLAG_SYNACK = 8'h12;
  localparam logic [7:0] FLAG_FINACK = 8'h11;

  // register reset values
  localparam logic [15:0] LISTEN_PORT_RST    = 16'd7;
  localparam logic [15:0] RECEIVE_WINDOW_RST = 16'd8192;
  localparam logic [15:0] MAX_SEGMENT_RST    = 16'd1460;

  typedef enum logic [1:0] {
    REG_LISTEN_PORT    = 2'd0,
    REG_RECEIVE_WINDOW = 2'd1,
    REG_MAX_SEGMENT    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_LISTEN   = 2'd0,
    ST_SYN_RCVD = 2'd1,
    ST_ESTAB    = 2'd2,
    ST_FIN_WAIT = 2'd3
  } conn_state_t;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_SEND    = 2'd1,
    OP_CLOSE   = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_ESTAB  = 3'd1,
    EV_DATA   = 3'd2,
    EV_SENT   = 3'd3,
    EV_CLOSED = 3'd4
  } event_t;

  typedef struct packed {
    logic [15:0] listen_port;
    logic [15:0] receive_window;
    logic [15:0] max_segment;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  seg_flags;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] payload_length;
    logic [15:0] peer_window;
    logic [15:0] dest_port;
    logic [31:0] initial_seq;
  } item_t;

  typedef struct packed {
    logic        seg_valid;
    logic [7:0]  out_flags;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [15:0] window_out;
    logic [15:0] data_offset;
    logic [15:0] data_length;
    logic        start_timer;
    event_t      event_res;
    conn_state_t state_now;
  } result_t;

endpackage

@@ hw/rtl/tcs_if.sv @@
// input word channel
interface tcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  seg_flags;
  logic [31:0] seq_num;
  logic [31:0] ack_num;
  logic [15:0] payload_length;
  logic [15:0] peer_window;
  logic [15:0] dest_port;
  logic [31:0] initial_seq;

  modport source (
    output valid, op, seg_flags, seq_num, ack_num, payload_length, peer_window,
           dest_port, initial_seq,
    input  ready
  );
  modport sink (
    input  valid, op, seg_flags, seq_num, ack_num, payload_length, peer_window,
           dest_port, initial_seq,
    output ready
  );
endinterface

// result word channel
interface tcs_out_if;
  logic        valid;
  logic        ready;
  logic        seg_valid;
  logic [7:0]  out_flags;
  logic [31:0] seq_out;
  logic [31:0] ack_out;
  logic [15:0] window_out;
  logic [15:0] data_offset;
  logic [15:0] data_length;
  logic        start_timer;
  logic [2:0]  event_res;
  logic [1:0]  state_now;

  modport source (
    output valid, seg_valid, out_flags, seq_out, ack_out, window_out, data_offset,
           data_length, start_timer, event_res, state_now,
    input  ready
  );
  modport sink (
    input  valid, seg_valid, out_flags, seq_out, ack_out, window_out, data_offset,
           data_length, start_timer, event_res, state_now,
    output ready
  );
endinterface

@@ hw/rtl/tcs_cfg.sv @@
module tcs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tcs_pkg::cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // register writes, word index from paddr[3:2]
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listen_port    <= tcs_pkg::LISTEN_PORT_RST;
      cfg.receive_window <= tcs_pkg::RECEIVE_WINDOW_RST;
      cfg.max_segment    <= tcs_pkg::MAX_SEGMENT_RST;
    end else if (wr) begin
      case (tcs_pkg::cfg_reg_t'(paddr[3:2]))
        tcs_pkg::REG_LISTEN_PORT:    cfg.listen_port    <= pwdata[15:0];
        tcs_pkg::REG_RECEIVE_WINDOW: cfg.receive_window <= pwdata[15:0];
        tcs_pkg::REG_MAX_SEGMENT:    cfg.max_segment    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (tcs_pkg::cfg_reg_t'(paddr[3:2]))
      tcs_pkg::REG_LISTEN_PORT:    prdata = {16'd0, cfg.listen_port};
      tcs_pkg::REG_RECEIVE_WINDOW: prdata = {16'd0, cfg.receive_window};
      tcs_pkg::REG_MAX_SEGMENT:    prdata = {16'd0, cfg.max_segment};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

@@ hw/rtl/tcs_core.sv @@
module tcs_core (
  input  logic          clk,
  input  logic          rst,
  input  tcs_pkg::cfg_t cfg,
  tcs_in_if.sink        item_ch,
  tcs_out_if.source     result_ch
);

  typedef struct packed {
    logic        emit;
    logic [15:0] off;
    logic [15:0] len;
    logic        timer;
    logic [31:0] snd_seq;
    logic [31:0] snd_top;
    logic [15:0] q_off;
    logic [15:0] q_rem;
  } sq_t;

  // send one segment from the queue: retransmit up to the high mark, else new data
  function automatic sq_t send_q(
    input logic [31:0] sn,
    input logic [31:0] su,
    input logic [31:0] sm,
    input logic [31:0] qfs,
    input logic [15:0] qoff,
    input logic [15:0] qrem,
    input logic [15:0] pw,
    input logic [15:0] mss
  );
    sq_t         r;
    logic [31:0] gap;
    logic [31:0] flight;
    logic [31:0] q_pos;
    logic [15:0] n;
    r.emit    = 1'b0;
    r.off     = 16'd0;
    r.len     = 16'd0;
    r.timer   = 1'b0;
    r.snd_seq = sn;
    r.snd_top = sm;
    r.q_off   = qoff;
    r.q_rem   = qrem;
    if (sn < sm) begin
      gap       = sm - sn;
      n         = (gap > 32'h0000_FFFF) ? 16'hFFFF : gap[15:0];
      q_pos     = sn - qfs;
      r.emit    = 1'b1;
      r.off     = q_pos[15:0];
      r.len     = n;
      r.snd_seq = sn + {16'd0, n};
    end else begin
      flight = sn - su;
      n = (flight >= {16'd0, pw}) ? 16'd0 : (pw - flight[15:0]);
      if (qrem < n) n = qrem;
      if (mss < n) n = mss;
      if (n != 16'd0) begin
        r.emit    = 1'b1;
        r.off     = qoff;
        r.len     = n;
        r.timer   = 1'b1;
        r.snd_seq = sn + {16'd0, n};
        if (r.snd_seq > sm) r.snd_top = r.snd_seq;
        r.q_off   = qoff + n;
        r.q_rem   = qrem - n;
      end
    end
    return r;
  endfunction

  // input register and result register
  logic                 in_full;
  tcs_pkg::item_t       it;
  logic                 out_full;
  tcs_pkg::result_t     res;
  logic                 consume;
  logic                 take_in;

  // connection state
  tcs_pkg::conn_state_t conn_state, conn_state_next;
  logic [31:0]          rcv_seq, rcv_seq_next;
  logic [31:0]          snd_seq, snd_seq_next;
  logic [31:0]          snd_una, snd_una_next;
  logic [31:0]          snd_top, snd_top_next;
  logic [31:0]          q_first, q_first_next;
  logic [15:0]          q_bytes, q_bytes_next;
  logic [15:0]          q_off, q_off_next;
  logic [15:0]          q_rem, q_rem_next;
  logic [15:0]          peer_win, peer_win_next;

  tcs_pkg::result_t     res_next;
  logic                 has_res;
  logic                 do_send;
  logic                 do_drop;
  sq_t                  sq;

  // handshake: input register drains into result register
  assign consume       = in_full && (!out_full || result_ch.ready);
  assign item_ch.ready = !in_full || consume;
  assign take_in       = item_ch.valid && item_ch.ready;

  // decode of one word against the current state
  always_comb begin
    conn_state_next = conn_state;
    rcv_seq_next    = rcv_seq;
    snd_seq_next    = snd_seq;
    snd_una_next    = snd_una;
    snd_top_next    = snd_top;
    q_first_next    = q_first;
    q_bytes_next    = q_bytes;
    q_off_next      = q_off;
    q_rem_next      = q_rem;
    peer_win_next   = peer_win;
    res_next        = '0;
    res_next.event_res = tcs_pkg::EV_NONE;
    do_send         = 1'b0;
    do_drop         = 1'b0;
    sq              = '0;

    case (it.op)
      tcs_pkg::OP_SEGMENT: begin
        if (conn_state == tcs_pkg::ST_LISTEN) begin
          if ((it.seg_flags & tcs_pkg::FLAG_SYN) != 8'd0) begin
            res_next.seg_valid = 1'b1;
            if (it.dest_port == cfg.listen_port) begin
              rcv_seq_next       = it.seq_num + 32'd1;
              snd_una_next       = it.initial_seq;
              snd_seq_next       = it.initial_seq + 32'd1;
              res_next.out_flags = tcs_pkg::FLAG_SYNACK;
              res_next.seq_out   = it.initial_seq;
              res_next.ack_out   = it.seq_num + 32'd1;
              conn_state_next    = tcs_pkg::ST_SYN_RCVD;
            end else begin
              do_drop            = 1'b1;
              res_next.out_flags = tcs_pkg::FLAG_RST;
            end
          end
        end else begin
          peer_win_next = it.peer_window;
          if ((it.seg_flags & tcs_pkg::FLAG_PSHACK) == tcs_pkg::FLAG_PSHACK) begin
            // in-order data
            if (conn_state == tcs_pkg::ST_ESTAB && it.seq_num == rcv_seq) begin
              rcv_seq_next       = rcv_seq + {16'd0, it.payload_length};
              res_next.event_res = tcs_pkg::EV_DATA;
            end
          end else if ((it.seg_flags & tcs_pkg::FLAG_ACK) != 8'd0) begin
            if (conn_state == tcs_pkg::ST_SYN_RCVD) begin
              if (it.ack_num == snd_seq) begin
                snd_una_next       = it.ack_num;
                conn_state_next    = tcs_pkg::ST_ESTAB;
                res_next.event_res = tcs_pkg::EV_ESTAB;
              end else begin
                do_drop            = 1'b1;
                res_next.event_res = tcs_pkg::EV_CLOSED;
              end
            end else if (conn_state == tcs_pkg::ST_ESTAB) begin
              if (it.ack_num > snd_una) snd_una_next = it.ack_num;
              if (it.ack_num >= q_first + {16'd0, q_bytes}) begin
                q_first_next       = 32'd0;
                q_bytes_next       = 16'd0;
                res_next.event_res = tcs_pkg::EV_SENT;
              end else if (q_rem != 16'd0) begin
                do_send = 1'b1;
              end
            end else if (it.ack_num == snd_seq) begin
              // peer acked our FIN
              res_next.seg_valid = 1'b1;
              res_next.out_flags = tcs_pkg::FLAG_ACK;
              res_next.seq_out   = snd_seq;
              res_next.ack_out   = rcv_seq + 32'd1;
              do_drop            = 1'b1;
              res_next.event_res = tcs_pkg::EV_CLOSED;
            end
          end else if ((it.seg_flags & tcs_pkg::FLAG_RST) != 8'd0) begin
            do_drop            = 1'b1;
            res_next.event_res = tcs_pkg::EV_CLOSED;
          end else if ((it.seg_flags & tcs_pkg::FLAG_FIN) != 8'd0) begin
            if (conn_state == tcs_pkg::ST_ESTAB ||
                conn_state == tcs_pkg::ST_FIN_WAIT) begin
              rcv_seq_next       = rcv_seq + 32'd1;
              res_next.seg_valid = 1'b1;
              res_next.out_flags = tcs_pkg::FLAG_ACK;
              res_next.seq_out   = snd_seq;
              res_next.ack_out   = rcv_seq + 32'd1;
              if (conn_state == tcs_pkg::ST_FIN_WAIT) begin
                do_drop            = 1'b1;
                res_next.event_res = tcs_pkg::EV_CLOSED;
              end
            end
          end
        end
      end
      tcs_pkg::OP_SEND: begin
        if (conn_state == tcs_pkg::ST_ESTAB) begin
          q_bytes_next = it.payload_length;
          q_first_next = snd_seq;
          q_off_next   = 16'd0;
          q_rem_next   = it.payload_length;
          do_send      = 1'b1;
        end
      end
      tcs_pkg::OP_CLOSE: begin
        if (conn_state == tcs_pkg::ST_ESTAB) begin
          conn_state_next    = tcs_pkg::ST_FIN_WAIT;
          res_next.seg_valid = 1'b1;
          res_next.out_flags = tcs_pkg::FLAG_FINACK;
          res_next.seq_out   = snd_seq;
          res_next.ack_out   = rcv_seq;
          snd_seq_next       = snd_seq + 32'd1;
        end
      end
      tcs_pkg::OP_TIMEOUT: begin
        if (conn_state == tcs_pkg::ST_ESTAB) begin
          snd_seq_next = snd_una;
          do_send      = 1'b1;
        end
      end
      default: ;
    endcase

    // queue send works on the already updated pointers
    if (do_send) begin
      sq = send_q(snd_seq_next, snd_una_next, snd_top_next, q_first_next,
                  q_off_next, q_rem_next, peer_win_next, cfg.max_segment);
      if (sq.emit) begin
        res_next.seg_valid   = 1'b1;
        res_next.out_flags   = tcs_pkg::FLAG_PSHACK;
        res_next.seq_out     = snd_seq_next;
        res_next.ack_out     = rcv_seq_next;
        res_next.data_offset = sq.off;
        res_next.data_length = sq.len;
        res_next.start_timer = sq.timer;
      end
      snd_seq_next = sq.snd_seq;
      snd_top_next = sq.snd_top;
      q_off_next   = sq.q_off;
      q_rem_next   = sq.q_rem;
    end

    // connection dropped: back to listen with cleared pointers
    if (do_drop) begin
      conn_state_next = tcs_pkg::ST_LISTEN;
      rcv_seq_next    = 32'd0;
      snd_seq_next    = 32'd0;
      snd_una_next    = 32'd0;
      snd_top_next    = 32'd0;
      q_first_next    = 32'd0;
      q_bytes_next    = 16'd0;
      q_off_next      = 16'd0;
      q_rem_next      = 16'd0;
      peer_win_next   = 16'd0;
    end

    if (res_next.seg_valid) res_next.window_out = cfg.receive_window;
    res_next.state_now = conn_state_next;
    has_res = res_next.seg_valid || (res_next.event_res != tcs_pkg::EV_NONE);
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      out_full   <= 1'b0;
      conn_state <= tcs_pkg::ST_LISTEN;
      rcv_seq    <= 32'd0;
      snd_seq    <= 32'd0;
      snd_una    <= 32'd0;
      snd_top    <= 32'd0;
      q_first    <= 32'd0;
      q_bytes    <= 16'd0;
      q_off      <= 16'd0;
      q_rem      <= 16'd0;
      peer_win   <= 16'd0;
    end else begin
      in_full  <= take_in || (in_full && !consume);
      out_full <= (consume && has_res) || (out_full && !result_ch.ready);
      if (consume) begin
        conn_state <= conn_state_next;
        rcv_seq    <= rcv_seq_next;
        snd_seq    <= snd_seq_next;
        snd_una    <= snd_una_next;
        snd_top    <= snd_top_next;
        q_first    <= q_first_next;
        q_bytes    <= q_bytes_next;
        q_off      <= q_off_next;
        q_rem      <= q_rem_next;
        peer_win   <= peer_win_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      it.op             <= tcs_pkg::op_t'(item_ch.op);
      it.seg_flags      <= item_ch.seg_flags;
      it.seq_num        <= item_ch.seq_num;
      it.ack_num        <= item_ch.ack_num;
      it.payload_length <= item_ch.payload_length;
      it.peer_window    <= item_ch.peer_window;
      it.dest_port      <= item_ch.dest_port;
      it.initial_seq    <= item_ch.initial_seq;
    end
    if (consume && has_res) res <= res_next;
  end

  // result channel
  assign result_ch.valid       = out_full;
  assign result_ch.seg_valid   = res.seg_valid;
  assign result_ch.out_flags   = res.out_flags;
  assign result_ch.seq_out     = res.seq_out;
  assign result_ch.ack_out     = res.ack_out;
  assign result_ch.window_out  = res.window_out;
  assign result_ch.data_offset = res.data_offset;
  assign result_ch.data_length = res.data_length;
  assign result_ch.start_timer = res.start_timer;
  assign result_ch.event_res   = res.event_res;
  assign result_ch.state_now   = res.state_now;

endmodule

@@ hw/rtl/tcp_connection_fsm_sender.sv @@
// Passive-open TCP endpoint for a single connection, control path and send queue.
// item_ch carries one event word: a received segment header, an application
// send or close, or a retransmit timeout. result_ch returns at most one word
// per event: an emitted segment header and/or a connection event, plus the
// connection state after the event. Events that cause nothing return no word.
// listen_port, receive_window and max_segment sit on the APB port at byte
// offsets 0, 4 and 8; write them only while no event is in flight.
// A word accepted on item_ch is registered in the input register, decoded
// against the connection state and registered in the result register,
// which drives result_ch. Throughput is one word per cycle while result_ch
// takes words; the limit is the update of the sequence pointers in tcs_core.
// Reset (synchronous, rst high) puts the connection in listen with all
// pointers zero and the registers at 7, 8192 and 1460.
// When result_ch stalls, the result register holds its word and the input
// register holds one more; item_ch.ready drops only when both are full.
module tcp_connection_fsm_sender (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  tcs_in_if.sink                     item_ch,
  tcs_out_if.source                  result_ch
);

  tcs_pkg::cfg_t cfg;

  // configuration registers
  tcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // connection state and segment decode
  tcs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_ch   (item_ch),
    .result_ch (result_ch)
  );

endmodule

@@ verif/testbench.sv @@
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [tcs_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  tcs_in_if  in_ch();
  tcs_out_if out_ch();

  tcp_connection_fsm_sender dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .item_ch   (in_ch),
    .result_ch (out_ch)
  );

  always #5 clk = ~clk;

  // endpoint model: connection state and send queue
  tcs_pkg::conn_state_t conn_st;
  logic [31:0] rcv_nxt, snd_nxt, snd_una, snd_top, q_first;
  logic [15:0] q_bytes, q_off, q_left, peer_win;
  logic [15:0] cfg_port, cfg_rwin, cfg_mss;
  tcs_pkg::result_t pend;

  // result words still to come back, oldest first
  tcs_pkg::result_t words_due[$];
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  bit          steady = 1'b0;

  function automatic void drop_connection();
    conn_st = tcs_pkg::ST_LISTEN;
    rcv_nxt = '0;
    snd_nxt = '0;
    snd_una = '0;
    snd_top = '0;
    q_first = '0;
    q_bytes = '0;
    q_off   = '0;
    q_left  = '0;
    peer_win = '0;
  endfunction

  function automatic void put_header(logic [7:0] fl, logic [31:0] sq, logic [31:0] ak);
    pend.seg_valid   = 1'b1;
    pend.out_flags   = fl;
    pend.seq_out     = sq;
    pend.ack_out     = ak;
    pend.data_offset = '0;
    pend.data_length = '0;
    pend.start_timer = 1'b0;
  endfunction

  // next data segment: resend up to the highest sent byte, else new bytes
  function automatic void send_queued_bytes();
    logic [31:0] n;
    logic [31:0] flight;
    if (snd_nxt < snd_top) begin
      n = snd_top - snd_nxt;
      if (n > 32'h0000_FFFF) n = 32'h0000_FFFF;
      put_header(tcs_pkg::FLAG_PSHACK, snd_nxt, rcv_nxt);
      pend.data_offset = 16'(snd_nxt - q_first);
      pend.data_length = n[15:0];
      snd_nxt = snd_nxt + n;
      if (snd_nxt > snd_top) snd_top = snd_nxt;
    end else begin
      flight = snd_nxt - snd_una;
      n = (flight >= 32'(peer_win)) ? 32'd0 : 32'(peer_win) - flight;
      if (32'(q_left) < n) n = 32'(q_left);
      if (32'(cfg_mss) < n) n = 32'(cfg_mss);
      if (n != 0) begin
        put_header(tcs_pkg::FLAG_PSHACK, snd_nxt, rcv_nxt);
        pend.data_offset = q_off;
        pend.data_length = n[15:0];
        pend.start_timer = 1'b1;
        snd_nxt = snd_nxt + n;
        if (snd_nxt > snd_top) snd_top = snd_nxt;
        q_off  = q_off + n[15:0];
        q_left = q_left - n[15:0];
      end
    end
  endfunction

  function automatic void take_segment(tcs_pkg::item_t it);
    logic [31:0] q_end;
    q_end = q_first + 32'(q_bytes);
    if (conn_st == tcs_pkg::ST_LISTEN) begin
      if ((it.seg_flags & tcs_pkg::FLAG_SYN) == 8'h00) return;
      if (it.dest_port == cfg_port) begin
        rcv_nxt = it.seq_num + 32'd1;
        snd_nxt = it.initial_seq;
        snd_una = it.initial_seq;
        put_header(tcs_pkg::FLAG_SYNACK, snd_nxt, rcv_nxt);
        snd_nxt = snd_nxt + 32'd1;
        conn_st = tcs_pkg::ST_SYN_RCVD;
      end else begin
        drop_connection();
        put_header(tcs_pkg::FLAG_RST, 32'd0, 32'd0);
      end
      return;
    end
    peer_win = it.peer_window;
    // flag priority: PSH+ACK, ACK, RST, FIN
    if ((it.seg_flags & tcs_pkg::FLAG_PSHACK) == tcs_pkg::FLAG_PSHACK) begin
      if (conn_st == tcs_pkg::ST_ESTAB && it.seq_num == rcv_nxt) begin
        rcv_nxt = rcv_nxt + 32'(it.payload_length);
        pend.event_res = tcs_pkg::EV_DATA;
      end
    end else if ((it.seg_flags & tcs_pkg::FLAG_ACK) != 8'h00) begin
      if (conn_st == tcs_pkg::ST_SYN_RCVD) begin
        if (it.ack_num == snd_nxt) begin
          snd_una = it.ack_num;
          conn_st = tcs_pkg::ST_ESTAB;
          pend.event_res = tcs_pkg::EV_ESTAB;
        end else begin
          drop_connection();
          pend.event_res = tcs_pkg::EV_CLOSED;
        end
      end else if (conn_st == tcs_pkg::ST_ESTAB) begin
        if (it.ack_num > snd_una) snd_una = it.ack_num;
        if (it.ack_num >= q_end) begin
          q_first = '0;
          q_bytes = '0;
          pend.event_res = tcs_pkg::EV_SENT;
        end else if (q_left != 0) begin
          send_queued_bytes();
        end
      end else if (it.ack_num == snd_nxt) begin
        rcv_nxt = rcv_nxt + 32'd1;
        put_header(tcs_pkg::FLAG_ACK, snd_nxt, rcv_nxt);
        drop_connection();
        pend.event_res = tcs_pkg::EV_CLOSED;
      end
    end else if ((it.seg_flags & tcs_pkg::FLAG_RST) != 8'h00) begin
      drop_connection();
      pend.event_res = tcs_pkg::EV_CLOSED;
    end else if ((it.seg_flags & tcs_pkg::FLAG_FIN) != 8'h00) begin
      if (conn_st == tcs_pkg::ST_ESTAB) begin
        rcv_nxt = rcv_nxt + 32'd1;
        put_header(tcs_pkg::FLAG_ACK, snd_nxt, rcv_nxt);
      end else if (conn_st == tcs_pkg::ST_FIN_WAIT) begin
        rcv_nxt = rcv_nxt + 32'd1;
        put_header(tcs_pkg::FLAG_ACK, snd_nxt, rcv_nxt);
        drop_connection();
        pend.event_res = tcs_pkg::EV_CLOSED;
      end
    end
  endfunction

  // apply one accepted word to the model and queue the word it should return
  function automatic void advance_connection(tcs_pkg::item_t it);
    pend = '0;
    if (it.op == tcs_pkg::OP_SEGMENT) begin
      take_segment(it);
    end else if (conn_st == tcs_pkg::ST_ESTAB) begin
      case (it.op)
        tcs_pkg::OP_SEND: begin
          q_bytes = it.payload_length;
          q_first = snd_nxt;
          q_off   = '0;
          q_left  = it.payload_length;
          send_queued_bytes();
        end
        tcs_pkg::OP_CLOSE: begin
          conn_st = tcs_pkg::ST_FIN_WAIT;
          put_header(tcs_pkg::FLAG_FINACK, snd_nxt, rcv_nxt);
          snd_nxt = snd_nxt + 32'd1;
        end
        default: begin
          snd_nxt = snd_una;
          send_queued_bytes();
        end
      endcase
    end
    if (pend.seg_valid || pend.event_res != tcs_pkg::EV_NONE) begin
      pend.window_out = pend.seg_valid ? cfg_rwin : 16'd0;
      pend.state_now  = conn_st;
      words_due.push_back(pend);
    end
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t mismatch %s: expected %h, got %h", $realtime, what, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_words
    tcs_pkg::result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t unexpected word: flags %h seq %h state %h", $realtime,
                   out_ch.out_flags, out_ch.seq_out, out_ch.state_now);
      end else begin
        want = words_due.pop_front();
        note_mismatch("seg_valid", want.seg_valid, out_ch.seg_valid);
        note_mismatch("out_flags", want.out_flags, out_ch.out_flags);
        note_mismatch("seq_out", want.seq_out, out_ch.seq_out);
        note_mismatch("ack_out", want.ack_out, out_ch.ack_out);
        note_mismatch("window_out", want.window_out, out_ch.window_out);
        note_mismatch("data_offset", want.data_offset, out_ch.data_offset);
        note_mismatch("data_length", want.data_length, out_ch.data_length);
        note_mismatch("start_timer", want.start_timer, out_ch.start_timer);
        note_mismatch("event_res", want.event_res, out_ch.event_res);
        note_mismatch("state_now", want.state_now, out_ch.state_now);
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      hold_left <= gap_len();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic tcs_pkg::item_t word(tcs_pkg::op_t op, logic [7:0] fl,
                                          logic [31:0] sq, logic [31:0] ak,
                                          logic [15:0] len, logic [15:0] win,
                                          logic [15:0] port, logic [31:0] isn);
    tcs_pkg::item_t it;
    it.op             = op;
    it.seg_flags      = fl;
    it.seq_num        = sq;
    it.ack_num        = ak;
    it.payload_length = len;
    it.peer_window    = win;
    it.dest_port      = port;
    it.initial_seq    = isn;
    return it;
  endfunction

  // drive one word, wait for the handshake, then maybe idle
  task automatic send_word(input tcs_pkg::item_t it);
    int unsigned gap;
    in_ch.valid          <= 1'b1;
    in_ch.op             <= it.op;
    in_ch.seg_flags      <= it.seg_flags;
    in_ch.seq_num        <= it.seq_num;
    in_ch.ack_num        <= it.ack_num;
    in_ch.payload_length <= it.payload_length;
    in_ch.peer_window    <= it.peer_window;
    in_ch.dest_port      <= it.dest_port;
    in_ch.initial_seq    <= it.initial_seq;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    advance_connection(it);
    gap = steady ? 0 : gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apb_access(input bit wr, input tcs_pkg::cfg_reg_t idx,
                            input logic [15:0] val, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= tcs_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register, then read it back
  task automatic write_reg(input tcs_pkg::cfg_reg_t idx, input logic [15:0] val);
    logic [31:0] rd;
    apb_access(1'b1, idx, val, rd);
    case (idx)
      tcs_pkg::REG_LISTEN_PORT:    cfg_port = val;
      tcs_pkg::REG_RECEIVE_WINDOW: cfg_rwin = val;
      default:                     cfg_mss  = val;
    endcase
    apb_access(1'b0, idx, 16'h0000, rd);
    note_mismatch("prdata", {16'h0000, val}, rd);
  endtask

  // let every expected word come back and the pipeline drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] port, input logic [15:0] rwin,
                            input logic [15:0] mss);
    settle();
    write_reg(tcs_pkg::REG_LISTEN_PORT, port);
    write_reg(tcs_pkg::REG_RECEIVE_WINDOW, rwin);
    write_reg(tcs_pkg::REG_MAX_SEGMENT, mss);
  endtask

  function automatic logic [15:0] pick_window();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 6000));
    if (r < 85) return 16'hFFFF;
    if (r < 92) return 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_send_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(1, 3000));
    if (r < 95) return 16'h0000;
    return 16'($urandom_range(3000, 65535));
  endfunction

  // mostly well-formed traffic for the current state, some noise
  function automatic tcs_pkg::item_t pick_word();
    tcs_pkg::item_t it;
    int unsigned    r;
    logic [31:0]    span;
    it = word(tcs_pkg::OP_SEGMENT, 8'h00, $urandom, $urandom, 16'($urandom),
              pick_window(), 16'($urandom), $urandom);
    if ($urandom_range(0, 99) < 10) begin
      it.op = tcs_pkg::op_t'($urandom_range(0, 3));
      it.seg_flags = 8'($urandom);
      return it;
    end
    r = $urandom_range(0, 99);
    case (conn_st)
      tcs_pkg::ST_LISTEN: begin
        it.seg_flags = (r < 25) ? (tcs_pkg::FLAG_SYN | 8'($urandom)) : tcs_pkg::FLAG_SYN;
        if ($urandom_range(0, 9) != 0) it.dest_port = cfg_port;
        if ($urandom_range(0, 7) == 0)
          it.initial_seq = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      end
      tcs_pkg::ST_SYN_RCVD: begin
        it.seq_num = rcv_nxt;
        if (r < 80) begin
          it.seg_flags = tcs_pkg::FLAG_ACK;
          it.ack_num = snd_nxt;
        end else if (r < 90) begin
          it.seg_flags = tcs_pkg::FLAG_ACK;
          it.ack_num = snd_nxt + 32'd1 + 32'($urandom_range(0, 100));
        end else begin
          it.seg_flags = tcs_pkg::FLAG_FIN;
        end
      end
      tcs_pkg::ST_ESTAB: begin
        it.seq_num = rcv_nxt;
        if (r < 25) begin
          it.seg_flags = tcs_pkg::FLAG_PSHACK;
          it.payload_length = 16'($urandom_range(0, 2000));
          if ($urandom_range(0, 9) == 0)
            it.seq_num = rcv_nxt + 32'($urandom_range(1, 1000));
        end else if (r < 40) begin
          it.op = tcs_pkg::OP_SEND;
          it.payload_length = pick_send_len();
        end else if (r < 65) begin
          it.seg_flags = tcs_pkg::FLAG_ACK;
          span = snd_nxt - snd_una;
          if ($urandom_range(0, 4) == 0) it.ack_num = q_first + 32'(q_bytes);
          else if (span <= 32'd100000) it.ack_num = snd_una + $urandom_range(0, span);
        end else if (r < 75) begin
          it.op = tcs_pkg::OP_TIMEOUT;
        end else if (r < 82) begin
          it.seg_flags = tcs_pkg::FLAG_FIN;
        end else if (r < 88) begin
          it.op = tcs_pkg::OP_CLOSE;
        end else if (r < 91) begin
          it.seg_flags = tcs_pkg::FLAG_RST;
        end else begin
          it.seg_flags = 8'($urandom) & ~tcs_pkg::FLAG_ACK;
        end
      end
      default: begin
        it.seq_num = rcv_nxt;
        if (r < 60) begin
          it.seg_flags = tcs_pkg::FLAG_ACK;
          it.ack_num = snd_nxt;
        end else if (r < 80) begin
          it.seg_flags = tcs_pkg::FLAG_ACK;
          it.ack_num = snd_nxt + 32'($urandom_range(1, 5000));
        end else begin
          it.seg_flags = tcs_pkg::FLAG_FIN;
        end
      end
    endcase
    return it;
  endfunction

  // send n random words
  task automatic run_traffic(input int unsigned n);
    repeat (n) send_word(pick_word());
  endtask

  // listen, handshake, data, send queue and close paths, one by one
  task automatic test_directed();
    // listen: ignored words and a refused SYN
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_ACK, 32'h0, 32'h0, 16'h0, 16'h0,
                   cfg_port, 32'h0));
    send_word(word(tcs_pkg::OP_SEND, 8'h00, 32'h0, 32'h0, 16'hFFFF, 16'h0, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_CLOSE, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_TIMEOUT, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_SYN, 32'h1234_5678, 32'hFFFF_FFFF,
                   16'h0, 16'hFFFF, cfg_port + 16'd1, 32'hFFFF_FFFF));
    // accepted SYN with wrapping seq, FIN ignored, bad ACK drops
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_SYN, 32'hFFFF_FFFF, 32'h0, 16'h0,
                   16'd500, cfg_port, 32'h0000_1000));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_FIN, rcv_nxt, snd_nxt, 16'h0,
                   16'd500, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_ACK, rcv_nxt, snd_nxt + 32'd7,
                   16'h0, 16'd500, 16'h0, 32'h0));
    // handshake with our sequence near wrap
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_SYN, 32'd100, 32'h0, 16'h0,
                   16'hFFFF, cfg_port, 32'hFFFF_FFF0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_ACK, rcv_nxt, snd_nxt, 16'h0,
                   16'hFFFF, 16'h0, 32'h0));
    // in-order data with every flag set, then out-of-order data
    send_word(word(tcs_pkg::OP_SEGMENT, 8'hFF, rcv_nxt, snd_nxt, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_PSHACK, rcv_nxt + 32'd1, snd_nxt,
                   16'd10, 16'hFFFF, 16'h0, 32'h0));
    // send, partial ACK, timeout, completing ACK
    send_word(word(tcs_pkg::OP_SEND, 8'h00, 32'h0, 32'h0, 16'd3000, 16'h0, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_ACK, rcv_nxt, snd_nxt, 16'h0,
                   16'hFFFF, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_TIMEOUT, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_ACK, rcv_nxt, q_first + 32'(q_bytes),
                   16'h0, 16'hFFFF, 16'h0, 32'h0));
    // FIN while established; a zero peer window holds back a send
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_FIN, rcv_nxt, snd_nxt, 16'h0,
                   16'hFFFF, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, 8'h00, rcv_nxt, snd_nxt, 16'h0, 16'h0, 16'h0,
                   32'h0));
    send_word(word(tcs_pkg::OP_SEND, 8'h00, 32'h0, 32'h0, 16'd100, 16'h0, 16'h0, 32'h0));
    // active close: wrong ACK ignored, FIN closes
    send_word(word(tcs_pkg::OP_CLOSE, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_ACK, rcv_nxt, snd_nxt + 32'd1,
                   16'h0, 16'd10, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_FIN, rcv_nxt, snd_nxt, 16'h0,
                   16'd10, 16'h0, 32'h0));
    // reset from the established state
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_SYN, 32'h0, 32'h0, 16'h0, 16'd0,
                   cfg_port, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_ACK, rcv_nxt, snd_nxt, 16'h0,
                   16'd800, 16'h0, 32'h0));
    send_word(word(tcs_pkg::OP_SEGMENT, tcs_pkg::FLAG_RST, rcv_nxt, snd_nxt, 16'h0,
                   16'd800, 16'h0, 32'h0));
  endtask

  // register extremes, each with a short stretch of traffic
  task automatic test_config_extremes();
    set_config(16'h0000, 16'h0000, 16'd1);
    run_traffic(40);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(40);
    set_config(16'($urandom), 16'($urandom), 16'($urandom_range(1, 200)));
    run_traffic(40);
  endtask

  // random traffic in chunks under changing settings
  task automatic test_random_traffic();
    repeat (5) begin
      set_config(($urandom_range(0, 1) == 0) ? tcs_pkg::LISTEN_PORT_RST : 16'($urandom),
                 16'($urandom),
                 ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(1, 2000)));
      steady = ($urandom_range(0, 3) == 0);
      run_traffic(70);
      steady = 1'b0;
    end
  endtask

  initial begin
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.op             <= tcs_pkg::OP_SEGMENT;
    in_ch.seg_flags      <= '0;
    in_ch.seq_num        <= '0;
    in_ch.ack_num        <= '0;
    in_ch.payload_length <= '0;
    in_ch.peer_window    <= '0;
    in_ch.dest_port      <= '0;
    in_ch.initial_seq    <= '0;
    cfg_port = tcs_pkg::LISTEN_PORT_RST;
    cfg_rwin = tcs_pkg::RECEIVE_WINDOW_RST;
    cfg_mss  = tcs_pkg::MAX_SEGMENT_RST;
    drop_connection();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random_traffic();

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_if.sv
hw/rtl/tcs_cfg.sv
hw/rtl/tcs_core.sv
hw/rtl/tcp_connection_fsm_sender.sv
verif/testbench.sv
